// ===== rtl/magic_hash_collision_check_core_macros.svh =====
// Assertion macros shared by the collision checker modules.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef MAGIC_HASH_COLLISION_CHECK_CORE_MACROS_SVH
`define MAGIC_HASH_COLLISION_CHECK_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHCC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mhcc_pkg.sv =====
// Types and constants shared by the magic hash collision checker.
// No dependencies; every other file of the block but the macro header refers to it by scoped names.
package mhcc_pkg;

	localparam int SLOT_W  = 12;
	localparam int DATA_W  = 64;
	localparam int SHIFT_W = 6;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd52;

	typedef enum logic {
		REG_MAGIC = 1'b0,
		REG_SHIFT = 1'b1
	} reg_index_t;

	// One classified pair as it travels from the front end to the table.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] moves;
		logic              first;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              collided;
		logic              trial_failed;
		logic              trial_end;
	} result_t;

	typedef enum logic {
		BK_SWEEP = 1'b0,
		BK_RUN   = 1'b1
	} back_state_t;

	typedef struct packed {
		logic sweeping;
	} back_status_t;

endpackage

// ===== rtl/mhcc_front.sv =====
// Front end: configuration registers, the split 64-bit multiply and slot extraction.
// Depends on mhcc_pkg.
module mhcc_front #(
	parameter int INDEX_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [0:0]                    wr_index,
	input  logic [mhcc_pkg::DATA_W-1:0]   wr_data,
	input  logic                          accept,
	input  logic [mhcc_pkg::DATA_W-1:0]   blocking,
	input  logic [mhcc_pkg::DATA_W-1:0]   moves,
	input  logic                          first,
	input  logic                          last,
	output logic                          valid_s2,
	output mhcc_pkg::item_t               item_s2,
	output logic [1:0]                    occupancy
);

	localparam logic [mhcc_pkg::SHIFT_W-1:0] MinShift =
		mhcc_pkg::SHIFT_W'(64 - INDEX_BITS);

	logic [63:0]                    magic_q;
	logic [mhcc_pkg::SHIFT_W-1:0]   shift_q;

	logic        valid_s1;
	logic [63:0] pll_s1;
	logic [31:0] phl_s1;
	logic [31:0] plh_s1;
	logic [63:0] moves_s1;
	logic        first_s1;
	logic        last_s1;

	logic [63:0]                  pll_d;
	logic [31:0]                  phl_d;
	logic [31:0]                  plh_d;
	logic [63:0]                  prod;
	logic [63:0]                  shifted;
	logic [mhcc_pkg::SHIFT_W-1:0] sh_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			shift_q <= mhcc_pkg::SHIFT_RESET;
		end else if (wr_en) begin
			case (mhcc_pkg::reg_index_t'(wr_index))
				mhcc_pkg::REG_MAGIC: magic_q <= wr_data;
				mhcc_pkg::REG_SHIFT: shift_q <= wr_data[mhcc_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// The low 64 bits of the product need one full 32x32 product and the low
	// halves of the two cross products.
	assign pll_d = 64'(blocking[31:0]) * 64'(magic_q[31:0]);
	assign phl_d = blocking[63:32] * magic_q[31:0];
	assign plh_d = blocking[31:0] * magic_q[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pll_s1   <= pll_d;
			phl_s1   <= phl_d;
			plh_s1   <= plh_d;
			moves_s1 <= moves;
			first_s1 <= first;
			last_s1  <= last;
		end
	end

	always_comb begin
		prod    = pll_s1 + {phl_s1 + plh_s1, 32'b0};
		sh_eff  = (shift_q < MinShift) ? MinShift : shift_q;
		shifted = prod >> sh_eff;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			item_s2.slot  <= mhcc_pkg::SLOT_W'(shifted[INDEX_BITS-1:0]);
			item_s2.moves <= moves_s1;
			item_s2.first <= first_s1;
			item_s2.last  <= last_s1;
		end
	end

	assign occupancy = {1'b0, valid_s1} + {1'b0, valid_s2};

endmodule

// ===== rtl/mhcc_queue.sv =====
// Short queue of classified pairs between the front end and the table back end.
// Depends on mhcc_pkg and the shared assertion macros.
`include "magic_hash_collision_check_core_macros.svh"

module mhcc_queue #(
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mhcc_pkg::item_t              push_item,
	input  logic                         pop,
	output logic                         head_valid,
	output mhcc_pkg::item_t              head_item,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	mhcc_pkg::item_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap at DEPTH, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign count      = count_q;

	`MHCC_ASSERT_IMPL(a_queue_no_overflow, push && !pop, count_q < CntW'(DEPTH), "queue overflow")
	`MHCC_ASSERT_IMPL(a_queue_no_underflow, pop, head_valid, "pop from empty queue")
	`MHCC_ASSERT_IMPL(a_queue_count_bound, 1'b1, count_q <= CntW'(DEPTH), "queue count too large")

endmodule

// ===== rtl/mhcc_back.sv =====
// Back end: move table with trial tags, clearing pass, collision check and result register.
// Depends on mhcc_pkg and the shared assertion macros.
`include "magic_hash_collision_check_core_macros.svh"

module mhcc_back #(
	parameter int INDEX_BITS = 12,
	parameter int EPOCH_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  mhcc_pkg::item_t        head_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mhcc_pkg::result_t      result,
	output mhcc_pkg::back_status_t status
);

	localparam int Depth  = 1 << INDEX_BITS;
	localparam int EntryW = mhcc_pkg::DATA_W + EPOCH_BITS;

	// Each entry carries the trial tag it was written under; a tag that differs
	// from the current one reads as an empty slot.
	logic [EntryW-1:0] mem_q [Depth];
	logic [EntryW-1:0] rd_q;

	mhcc_pkg::back_state_t state_q;
	mhcc_pkg::back_state_t state_d;
	logic [INDEX_BITS-1:0] sweep_idx_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic                  failed_q;

	logic                  valid_s1;
	mhcc_pkg::item_t       item_s1;

	logic                  fwd_valid_q;
	logic [INDEX_BITS-1:0] fwd_idx_q;
	logic [63:0]           fwd_data_q;

	logic                  out_valid_q;
	mhcc_pkg::result_t     result_q;

	logic [INDEX_BITS-1:0] idx_s1;
	logic [EPOCH_BITS-1:0] rd_tag;
	logic [EPOCH_BITS-1:0] epoch_new;
	logic [63:0]           held_mem;
	logic [63:0]           held;
	logic                  flag_in;
	logic                  hit;
	logic                  wrap_need;
	logic                  out_free;
	logic                  fire;
	logic                  wr_item;
	logic                  sweep_exit;

	always_comb begin
		idx_s1    = item_s1.slot[INDEX_BITS-1:0];
		rd_tag    = rd_q[EntryW-1:mhcc_pkg::DATA_W];
		held_mem  = (rd_tag == epoch_q) ? rd_q[mhcc_pkg::DATA_W-1:0] : '0;
		// The preceding write may have landed in the same cycle as this read.
		if (item_s1.first) begin
			held = '0;
		end else if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			held = fwd_data_q;
		end else begin
			held = held_mem;
		end
		flag_in   = item_s1.first ? 1'b0 : failed_q;
		hit       = !flag_in && (held != '0) && (held != item_s1.moves);
		epoch_new = item_s1.first ? (epoch_q + EPOCH_BITS'(1)) : epoch_q;
		wrap_need = valid_s1 && item_s1.first && (epoch_q == '1);
		out_free  = !out_valid_q || !out_stall;
		fire      = (state_q == mhcc_pkg::BK_RUN) && valid_s1 && out_free && !wrap_need;
		wr_item   = fire && !flag_in && !hit;
		pop       = (state_q == mhcc_pkg::BK_RUN) && head_valid && (!valid_s1 || fire);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mhcc_pkg::BK_SWEEP: begin
				if (sweep_idx_q == '1) begin
					state_d = mhcc_pkg::BK_RUN;
				end
			end
			mhcc_pkg::BK_RUN: begin
				if (wrap_need) begin
					state_d = mhcc_pkg::BK_SWEEP;
				end
			end
			default: state_d = mhcc_pkg::BK_SWEEP;
		endcase
	end

	assign sweep_exit = (state_q == mhcc_pkg::BK_SWEEP) && (state_d == mhcc_pkg::BK_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhcc_pkg::BK_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_idx_q <= '0;
			epoch_q     <= '0;
			failed_q    <= 1'b0;
			fwd_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mhcc_pkg::BK_SWEEP) begin
				sweep_idx_q <= sweep_idx_q + INDEX_BITS'(1);
				fwd_valid_q <= 1'b0;
				if (state_d == mhcc_pkg::BK_RUN) begin
					epoch_q <= '0;
				end
			end else if (wr_item) begin
				fwd_valid_q <= 1'b1;
			end
			if (fire) begin
				epoch_q  <= epoch_new;
				failed_q <= flag_in | hit;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mhcc_pkg::BK_SWEEP) begin
			mem_q[sweep_idx_q] <= '0;
		end else if (wr_item) begin
			mem_q[idx_s1] <= {epoch_new, item_s1.moves};
		end
		if (pop) begin
			rd_q <= mem_q[head_item.slot[INDEX_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_item;
		end
		if (wr_item) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= item_s1.moves;
		end
		if (fire) begin
			result_q.slot         <= mhcc_pkg::SLOT_W'(idx_s1);
			result_q.collided     <= hit;
			result_q.trial_failed <= flag_in | hit;
			result_q.trial_end    <= item_s1.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign result          = result_q;
	assign status.sweeping = (state_q == mhcc_pkg::BK_SWEEP);

	`MHCC_ASSERT_IMPL(a_idle_during_sweep, status.sweeping, !pop && !fire, "access while clearing")
	`MHCC_ASSERT_NEXT(a_sweep_exit, sweep_exit, ~|epoch_q && !fwd_valid_q, "stale tag after clear")
	`MHCC_ASSERT_NEXT(a_hit_sets_flag, fire && hit, failed_q && out_valid_q, "flag not set")

endmodule

// ===== rtl/magic_hash_collision_check_core.sv =====
// Magic multiplier collision checker: one result transaction for every pair taken in.
// While neither in_stall nor out_stall holds it up, it takes one pair per cycle: the
// front end multiplies the occupancy by the magic in two pipeline stages, a queue of
// QUEUE_DEPTH entries decouples it from the back end, and the back end does one
// read-modify-write of the move table per cycle, reading one entry while writing another,
// and forwards the previous write. Results leave from the back end's result register.
// in_stall also rises while the queue and the multiply pipeline together hold QUEUE_DEPTH
// pairs. Table entries carry a trial tag of EPOCH_BITS bits, so a first pair normally
// clears the table at no cost; after reset, and when the (2^EPOCH_BITS)th pair marked
// first after reset, or every (2^EPOCH_BITS - 1)th such pair after that, reaches the back
// end, it runs a clearing pass over all 2^INDEX_BITS_MAX entries with in_stall high.
module magic_hash_collision_check_core #(
	parameter int INDEX_BITS_MAX = 12,
	parameter int EPOCH_BITS     = 8,
	parameter int QUEUE_DEPTH    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [0:0]                         wr_index,
	input  logic [mhcc_pkg::DATA_W-1:0]        wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [mhcc_pkg::DATA_W-1:0]        blocking,
	input  logic [mhcc_pkg::DATA_W-1:0]        moves,
	input  logic                               first,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mhcc_pkg::SLOT_W-1:0]        slot,
	output logic                               collided,
	output logic                               trial_failed,
	output logic                               trial_end
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic                   accept;
	logic                   front_valid;
	mhcc_pkg::item_t        front_item;
	logic [1:0]             front_occ;
	logic                   q_pop;
	logic                   q_valid;
	mhcc_pkg::item_t        q_item;
	logic [CntW-1:0]        q_count;
	logic [CntW:0]          fill;
	mhcc_pkg::result_t      result;
	mhcc_pkg::back_status_t back_status;

	// A pair is taken only if the queue can absorb it together with everything
	// still in the multiply pipeline.
	assign fill     = (CntW+1)'(q_count) + (CntW+1)'(front_occ);
	assign in_stall = back_status.sweeping | (fill >= (CntW+1)'(QUEUE_DEPTH));
	assign accept   = in_valid & ~in_stall;

	mhcc_front #(
		.INDEX_BITS (INDEX_BITS_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.accept    (accept),
		.blocking  (blocking),
		.moves     (moves),
		.first     (first),
		.last      (last),
		.valid_s2  (front_valid),
		.item_s2   (front_item),
		.occupancy (front_occ)
	);

	mhcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_item  (front_item),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_item),
		.count      (q_count)
	);

	mhcc_back #(
		.INDEX_BITS (INDEX_BITS_MAX),
		.EPOCH_BITS (EPOCH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_item  (q_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.status     (back_status)
	);

	assign slot         = result.slot;
	assign collided     = result.collided;
	assign trial_failed = result.trial_failed;
	assign trial_end    = result.trial_end;

endmodule

// ===== test/mhcc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the magic hash collision checker: follows the register port and both
// channels, predicts each pair's verdict and compares it with the block's result.
// Depends on mhcc_pkg for widths, register indexes and the result layout.
module mhcc_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [0:0]                  wr_index,
	input  logic [mhcc_pkg::DATA_W-1:0] wr_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [mhcc_pkg::DATA_W-1:0] blocking,
	input  logic [mhcc_pkg::DATA_W-1:0] moves,
	input  logic                        first,
	input  logic                        last,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [mhcc_pkg::SLOT_W-1:0] slot,
	input  logic                        collided,
	input  logic                        trial_failed,
	input  logic                        trial_end,
	output int                          verdicts_due,
	output int                          mismatch_count
);

	localparam int MIN_SHIFT = mhcc_pkg::DATA_W - mhcc_pkg::SLOT_W;

	bit [mhcc_pkg::DATA_W-1:0]  cfg_magic = '0;
	bit [mhcc_pkg::SHIFT_W-1:0] cfg_shift = mhcc_pkg::SHIFT_RESET;
	bit [mhcc_pkg::DATA_W-1:0]  move_mem [1 << mhcc_pkg::SLOT_W];
	bit                         trial_lost = 1'b0;
	mhcc_pkg::result_t          verdict_q [$];
	int                         due_count = 0;
	int                         mismatches = 0;

	assign verdicts_due   = due_count;
	assign mismatch_count = mismatches;

	// Works out the verdict of one pair and updates the move table and the sticky flag.
	function automatic mhcc_pkg::result_t classify_pair(logic [mhcc_pkg::DATA_W-1:0] occ,
			logic [mhcc_pkg::DATA_W-1:0] mv, logic is_first, logic is_last);
		logic [mhcc_pkg::DATA_W-1:0] product;
		int unsigned                 sh;
		mhcc_pkg::result_t           res;
		sh = (cfg_shift < MIN_SHIFT) ? MIN_SHIFT : cfg_shift;
		product = (occ * cfg_magic) >> sh;
		res.slot = product[mhcc_pkg::SLOT_W-1:0];
		res.collided = 1'b0;
		if (is_first) begin
			foreach (move_mem[i])
				move_mem[i] = '0;
			trial_lost = 1'b0;
		end
		// Once a trial has failed, later pairs leave the table alone.
		if (!trial_lost) begin
			if (move_mem[res.slot] != '0 && move_mem[res.slot] != mv) begin
				res.collided = 1'b1;
				trial_lost = 1'b1;
			end else begin
				move_mem[res.slot] = mv;
			end
		end
		res.trial_failed = trial_lost;
		res.trial_end = is_last;
		return res;
	endfunction

	task automatic check_field(string label, logic [mhcc_pkg::DATA_W-1:0] want,
			logic [mhcc_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		mhcc_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result transaction with none outstanding: slot %0h", slot);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					check_field("slot", want.slot, slot);
					check_field("collided", want.collided, collided);
					check_field("trial_failed", want.trial_failed, trial_failed);
					check_field("trial_end", want.trial_end, trial_end);
				end
			end
			if (wr_en) begin
				if (wr_index == mhcc_pkg::REG_MAGIC)
					cfg_magic = wr_data;
				else
					cfg_shift = wr_data[mhcc_pkg::SHIFT_W-1:0];
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(classify_pair(blocking, moves, first, last));
			due_count <= verdict_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for magic_hash_collision_check_core: clock, reset, register writes,
// pair stimulus and result back-pressure; the verdict comes from mhcc_result_checker.
// Depends on mhcc_pkg, the block itself and test/mhcc_result_checker.sv.
module tb;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        wr_en = 1'b0;
	logic [0:0]                  wr_index = mhcc_pkg::REG_MAGIC;
	logic [mhcc_pkg::DATA_W-1:0] wr_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [mhcc_pkg::DATA_W-1:0] blocking = '0;
	logic [mhcc_pkg::DATA_W-1:0] moves = '0;
	logic                        first = 1'b0;
	logic                        last = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [mhcc_pkg::SLOT_W-1:0] slot;
	logic                        collided;
	logic                        trial_failed;
	logic                        trial_end;
	int                          verdicts_due;
	int                          mismatch_count;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always #2 clk = ~clk;

	magic_hash_collision_check_core u_top (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.blocking(blocking), .moves(moves), .first(first), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .collided(collided), .trial_failed(trial_failed), .trial_end(trial_end)
	);

	mhcc_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.blocking(blocking), .moves(moves), .first(first), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .collided(collided), .trial_failed(trial_failed), .trial_end(trial_end),
		.verdicts_due(verdicts_due), .mismatch_count(mismatch_count)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_pair(logic [mhcc_pkg::DATA_W-1:0] occ, logic [mhcc_pkg::DATA_W-1:0] mv,
			logic is_first, logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		blocking <= occ;
		moves <= mv;
		first <= is_first;
		last <= is_last;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stops sending and waits until every outstanding result transaction has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (verdicts_due != 0);
	endtask

	task automatic set_config(logic [mhcc_pkg::DATA_W-1:0] magic_val,
			logic [mhcc_pkg::SHIFT_W-1:0] shift_val);
		drain();
		wr_en <= 1'b1;
		wr_index <= mhcc_pkg::REG_MAGIC;
		wr_data <= magic_val;
		@(posedge clk);
		wr_index <= mhcc_pkg::REG_SHIFT;
		wr_data <= {{(mhcc_pkg::DATA_W-mhcc_pkg::SHIFT_W){1'b0}}, shift_val};
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// One trial: mostly fresh occupancies with consistent move sets, some repeats, and a few
	// conflicting or empty move sets. A broken trial has random first and last marks.
	task automatic run_trial(int len, bit broken);
		logic [mhcc_pkg::DATA_W-1:0] pool [$];
		logic [mhcc_pkg::DATA_W-1:0] occ;
		logic [mhcc_pkg::DATA_W-1:0] mv;
		int                          pick;
		logic                        f;
		logic                        l;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pool.size() == 0 || pick < 55) begin
				occ = {$urandom, $urandom};
				if ($urandom_range(1))
					occ &= {$urandom, $urandom} & {$urandom, $urandom};
				pool.push_back(occ);
			end else begin
				occ = pool[$urandom_range(pool.size() - 1)];
			end
			mv = {occ[40:0], occ[63:41]} ^ ~occ;
			if (pick >= 85 && pick < 93)
				mv = {$urandom, $urandom};
			else if (pick >= 93)
				mv = '0;
			f = (i == 0);
			l = (i == len - 1);
			if (broken) begin
				f = ($urandom_range(3) == 0);
				l = ($urandom_range(3) == 0);
			end
			send_pair(occ, mv, f, l);
		end
	endtask

	initial begin
		int                           items_sent;
		int                           phase_items;
		int                           len;
		int                           pick;
		logic [mhcc_pkg::DATA_W-1:0]  magic_val;
		logic [mhcc_pkg::SHIFT_W-1:0] shift_val;

		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// A zero magic sends every pair to slot 0.
		set_config('0, mhcc_pkg::SHIFT_RESET);
		send_pair('0, '0, 1'b1, 1'b0);
		send_pair('1, 64'd5, 1'b0, 1'b0);
		send_pair(64'h8000_0000_0000_0001, 64'd5, 1'b0, 1'b0);
		send_pair(64'h0123_4567_89ab_cdef, 64'd6, 1'b0, 1'b0);
		send_pair(64'h0000_0000_ffff_0000, 64'd7, 1'b0, 1'b1);
		send_pair('1, 64'd7, 1'b1, 1'b1);
		// Without a first mark the next trial starts from the table left behind.
		send_pair(64'd3, 64'd8, 1'b0, 1'b0);
		send_pair(64'd4, 64'd8, 1'b1, 1'b0);
		send_pair(64'd9, '1, 1'b0, 1'b1);

		// Largest shift: only the top bit of the product selects the slot.
		set_config('1, 6'd63);
		send_pair(64'd1, 64'haaaa_5555_aaaa_5555, 1'b1, 1'b0);
		send_pair('1, 64'h5555_aaaa_5555_aaaa, 1'b0, 1'b0);
		send_pair(64'd2, 64'haaaa_5555_aaaa_5555, 1'b0, 1'b0);
		send_pair(64'h8000_0000_0000_0000, '1, 1'b0, 1'b0);
		send_pair(64'd3, 64'h1, 1'b0, 1'b1);

		// A shift below the table's range is raised to the smallest legal one.
		set_config(64'h9d39_247e_3377_6d41, '0);
		send_pair('1, 64'h1234, 1'b1, 1'b0);
		send_pair(64'h0000_0000_0000_8000, 64'h1234, 1'b0, 1'b0);
		send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b1);
		set_config(64'hf0f0_0f0f_3c3c_c3c3, 6'd51);
		send_pair({$urandom, $urandom}, '1, 1'b1, 1'b0);
		send_pair({$urandom, $urandom}, '1, 1'b0, 1'b1);

		for (int ph = 0; items_sent < 1600; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			magic_val = {$urandom, $urandom};
			if ($urandom_range(9) == 0)
				magic_val &= {$urandom, $urandom};
			pick = $urandom_range(19);
			if (pick == 0)
				shift_val = 6'd52;
			else if (pick == 1)
				shift_val = 6'd63;
			else if (pick == 2)
				shift_val = mhcc_pkg::SHIFT_W'($urandom_range(51));
			else
				shift_val = mhcc_pkg::SHIFT_W'($urandom_range(52, 63));
			set_config(magic_val, shift_val);
			phase_items = 0;
			while (phase_items < 120) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
				run_trial(len, $urandom_range(99) < 15);
				phase_items += len;
			end
			items_sent += phase_items;
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
